[hw/rtl/bgi_pkg.sv]
// Package for the bilinear grid interpolator: beat types, state codes and constants.
package bgi_pkg;

  // Largest number of grid points on each axis.
  localparam int MAX_POINTS = 16;

  // Unity in the unsigned Q1.16 fraction and weight domain.
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // Quotient bits that the fraction divider produces, one per cycle.
  localparam logic [4:0] DIV_STEPS = 5'd17;

  // Command codes of the input beat.
  localparam logic [1:0] CMD_QUERY  = 2'd0;
  localparam logic [1:0] CMD_LOAD_X = 2'd1;
  localparam logic [1:0] CMD_LOAD_Y = 2'd2;
  localparam logic [1:0] CMD_LOAD_Z = 2'd3;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_X_COUNT = 1'b0;
  localparam logic REG_Y_COUNT = 1'b1;

  // Input beat.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic signed [31:0] z_value;
    logic [3:0]         x_cell;
    logic [3:0]         y_cell;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_START,
    ST_A_G0,
    ST_A_GL,
    ST_A_DN,
    ST_A_UP,
    ST_A_P0,
    ST_A_P1,
    ST_A_DIV,
    ST_A_END,
    ST_Z00,
    ST_Z01,
    ST_ZX0,
    ST_ZS0,
    ST_Z11,
    ST_ZX1,
    ST_ZS1,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/bilinear_grid_interpolator.sv]
// Bilinear grid interpolator: grid and table memories, cell search, divider and blend.
// A load beat is written when accepted. A query on a 1x1 grid goes straight to the blend;
// otherwise both axes are searched in turn, then blended, with more steps when x interpolates.
// An axis of one point skips the search, one clamped to an end stops at its end points, and
// one that interpolates walks from its hint to the cell and divides, unless it is of zero
// width. One query at a time; the next beat is taken once its result has loaded. Reset
// clears the control state and the hints and sets both counts to 1; memories are undefined.
module bilinear_grid_interpolator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bgi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bgi_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import bgi_pkg::*;

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int ZDEPTH = MAX_POINTS * MAX_POINTS;
  localparam int ZAW   = $clog2(ZDEPTH);

  // Memories.
  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [31:0] y_mem [MAX_POINTS];
  logic signed [31:0] z_mem [ZDEPTH];

  // Control registers.
  state_t        state_r, state_nxt;
  logic          out_valid_r;
  logic [4:0]    x_count_r, y_count_r;
  logic [PW-1:0] x_hint_r, y_hint_r;

  // Datapath registers.
  out_item_t          out_data_r;
  logic signed [31:0] qx_r, qy_r;
  logic               axis_r;
  logic [PW-1:0]      cur_i_r;
  logic               cur_two_r;
  logic [16:0]        cur_f_r;
  logic signed [31:0] g0_r, p0_r;
  logic signed [31:0] xg_rd_r, yg_rd_r, z_rd_r;
  logic [31:0]        div_rem_r, div_d_r;
  logic [16:0]        div_low_r, div_q_r;
  logic [4:0]         div_cnt_r;
  logic [PW-1:0]      i_r, j_r;
  logic               twox_r, twoy_r;
  logic [16:0]        fx_r, fy_r;
  logic signed [49:0] acc_r;
  logic signed [67:0] s_r;

  // Combinational signals.
  logic               in_acc, cfg_wr;
  logic [CW-1:0]      nx, ny, cur_n;
  logic signed [31:0] cur_q, g_data;
  logic [PW-1:0]      cur_hint, hint_cl, up_fin;
  logic [PW-1:0]      g_addr;
  logic [ZAW-1:0]     z_addr;
  logic [31:0]        a00, a10;
  logic               dn_go, up_go;
  logic signed [32:0] diff_d, diff_n;
  logic [31:0]        num_c;
  logic [48:0]        div_n;
  logic [32:0]        div_t, div_sub;
  logic               div_ge;
  logic [16:0]        div_q_nxt;
  logic [16:0]        wz, wx;
  logic signed [49:0] mz;
  logic signed [67:0] ms, s_rnd;
  logic signed [35:0] r_full;
  logic signed [31:0] z_sat;
  logic               out_load;

  assign in_acc    = in_valid && in_ready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_Y_COUNT) ? {27'd0, y_count_r} : {27'd0, x_count_r};

  // Effective point counts, limited to 1..MAX_POINTS.
  always_comb begin
    if (x_count_r == 5'd0) begin
      nx = CW'(1);
    end else if (32'(x_count_r) > 32'(MAX_POINTS)) begin
      nx = CW'(MAX_POINTS);
    end else begin
      nx = CW'(x_count_r);
    end
    if (y_count_r == 5'd0) begin
      ny = CW'(1);
    end else if (32'(y_count_r) > 32'(MAX_POINTS)) begin
      ny = CW'(MAX_POINTS);
    end else begin
      ny = CW'(y_count_r);
    end
  end

  // Per-axis view of the search.
  assign cur_n    = axis_r ? ny : nx;
  assign cur_q    = axis_r ? qy_r : qx_r;
  assign cur_hint = axis_r ? y_hint_r : x_hint_r;
  assign g_data   = axis_r ? yg_rd_r : xg_rd_r;
  assign hint_cl  = (32'(cur_hint) > 32'(cur_n) - 32'd1) ? PW'(cur_n - CW'(1)) : cur_hint;
  assign dn_go    = (cur_i_r != '0) && (cur_q < g_data);
  assign up_go    = (32'(cur_i_r) + 32'd2 < 32'(cur_n)) && (g_data < cur_q);
  assign up_fin   = (32'(cur_i_r) + 32'd1 >= 32'(cur_n)) ? PW'(cur_n - CW'(2)) : cur_i_r;

  // Fraction set-up: cell width and clamped offset.
  assign diff_d = {p0_r[31], p0_r};
  always_comb begin
    diff_n = {cur_q[31], cur_q} - {p0_r[31], p0_r};
    num_c  = diff_n[31:0];
    if (diff_n[32]) begin
      num_c = 32'd0;
    end else if (diff_n > ({g_data[31], g_data} - diff_d)) begin
      num_c = 32'(({g_data[31], g_data} - diff_d));
    end
  end

  // Divider operand: offset scaled to Q0.16 plus half the width for rounding.
  assign div_n = 49'({num_c, 16'd0}) +
                 49'(32'(($signed({g_data[31], g_data}) - diff_d) >>> 1));

  // Divider step: one quotient bit per cycle.
  assign div_t     = {div_rem_r, div_low_r[16]};
  assign div_sub   = div_t - {1'b0, div_d_r};
  assign div_ge    = (div_t >= {1'b0, div_d_r});
  assign div_q_nxt = {div_q_r[15:0], div_ge};

  // Table addresses of the corners at (i, j) and (i+1, j); the other two add one.
  assign a00 = 32'(i_r) * 32'(ny) + 32'(j_r);
  assign a10 = a00 + 32'(ny);

  // Weighting multipliers, one per cycle each.
  assign wz = ((state_r == ST_Z01) || (state_r == ST_Z11)) ? (FRAC_ONE - fy_r) : fy_r;
  assign wx = (state_r == ST_ZS0) ? (FRAC_ONE - fx_r) : fx_r;
  assign mz = z_rd_r * $signed({1'b0, wz});
  assign ms = acc_r * $signed({1'b0, wx});

  // Divide by 2^32 rounding half up, then saturate.
  assign s_rnd  = s_r + 68'sd2147483648;
  assign r_full = s_rnd[67:32];
  always_comb begin
    if (r_full > 36'sd2147483647) begin
      z_sat = 32'sh7FFFFFFF;
    end else if (r_full < -36'sd2147483648) begin
      z_sat = 32'sh80000000;
    end else begin
      z_sat = r_full[31:0];
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Next state and memory read addresses.
  always_comb begin
    state_nxt = state_r;
    g_addr    = cur_i_r;
    z_addr    = ZAW'(a00);
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.cmd == CMD_QUERY)) begin
          if ((nx == CW'(1)) && (ny == CW'(1))) begin
            state_nxt = ST_Z00;
          end else begin
            state_nxt = ST_A_START;
          end
        end
      end
      ST_A_START: begin
        g_addr = '0;
        state_nxt = (cur_n == CW'(1)) ? ST_A_END : ST_A_G0;
      end
      ST_A_G0: begin
        g_addr = PW'(cur_n - CW'(1));
        state_nxt = ST_A_GL;
      end
      ST_A_GL: begin
        g_addr = hint_cl;
        if ((cur_q <= g0_r) || (g_data <= cur_q)) begin
          state_nxt = ST_A_END;
        end else begin
          state_nxt = ST_A_DN;
        end
      end
      ST_A_DN: begin
        if (dn_go) begin
          g_addr = cur_i_r - PW'(1);
        end else begin
          g_addr = cur_i_r + PW'(1);
          state_nxt = ST_A_UP;
        end
      end
      ST_A_UP: begin
        if (up_go) begin
          g_addr = cur_i_r + PW'(2);
        end else begin
          g_addr = up_fin;
          state_nxt = ST_A_P0;
        end
      end
      ST_A_P0: begin
        g_addr = cur_i_r + PW'(1);
        state_nxt = ST_A_P1;
      end
      ST_A_P1: begin
        if (($signed({g_data[31], g_data}) - diff_d) <= 33'sd0) begin
          state_nxt = ST_A_END;
        end else begin
          state_nxt = ST_A_DIV;
        end
      end
      ST_A_DIV: begin
        if (div_cnt_r == 5'd1) begin
          state_nxt = ST_A_END;
        end
      end
      ST_A_END: begin
        state_nxt = axis_r ? ST_Z00 : ST_A_START;
      end
      ST_Z00: begin
        z_addr = ZAW'(a00);
        state_nxt = ST_Z01;
      end
      ST_Z01: begin
        z_addr = ZAW'(a00 + 32'd1);
        state_nxt = ST_ZX0;
      end
      ST_ZX0: begin
        state_nxt = ST_ZS0;
      end
      ST_ZS0: begin
        z_addr = ZAW'(a10);
        state_nxt = twox_r ? ST_Z11 : ST_DONE;
      end
      ST_Z11: begin
        z_addr = ZAW'(a10 + 32'd1);
        state_nxt = ST_ZX1;
      end
      ST_ZX1: begin
        state_nxt = ST_ZS1;
      end
      ST_ZS1: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers, hints and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      x_count_r   <= 5'd1;
      y_count_r   <= 5'd1;
      x_hint_r    <= '0;
      y_hint_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end
      if (cfg_wr && cfg_pready) begin
        if (cfg_paddr[2] == REG_X_COUNT) begin
          x_count_r <= cfg_pwdata[4:0];
        end else begin
          y_count_r <= cfg_pwdata[4:0];
        end
      end
      if (state_r == ST_A_END) begin
        if (axis_r) begin
          y_hint_r <= cur_i_r;
        end else begin
          x_hint_r <= cur_i_r;
        end
      end
    end
  end

  // Grid memories: write on a load beat, registered read.
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.cmd == CMD_LOAD_X) &&
        (32'(in_data.entry_index) < 32'(MAX_POINTS))) begin
      x_mem[PW'(in_data.entry_index)] <= in_data.entry_value;
    end
    xg_rd_r <= x_mem[g_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.cmd == CMD_LOAD_Y) &&
        (32'(in_data.entry_index) < 32'(MAX_POINTS))) begin
      y_mem[PW'(in_data.entry_index)] <= in_data.entry_value;
    end
    yg_rd_r <= y_mem[g_addr];
  end

  // Table memory.
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.cmd == CMD_LOAD_Z) &&
        (32'(in_data.entry_index) < ZDEPTH)) begin
      z_mem[ZAW'(in_data.entry_index)] <= in_data.entry_value;
    end
    z_rd_r <= z_mem[z_addr];
  end

  // Search, divider and blend datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.cmd == CMD_QUERY)) begin
          qx_r   <= in_data.query_x;
          qy_r   <= in_data.query_y;
          axis_r <= 1'b0;
          i_r    <= '0;
          j_r    <= '0;
          twox_r <= 1'b0;
          twoy_r <= 1'b0;
          fx_r   <= '0;
          fy_r   <= '0;
        end
      end
      ST_A_START: begin
        cur_i_r   <= '0;
        cur_two_r <= 1'b0;
        cur_f_r   <= '0;
      end
      ST_A_G0: begin
        g0_r <= g_data;
      end
      ST_A_GL: begin
        if (cur_q <= g0_r) begin
          cur_i_r <= '0;
        end else if (g_data <= cur_q) begin
          cur_i_r <= PW'(cur_n - CW'(1));
        end else begin
          cur_two_r <= 1'b1;
          cur_i_r   <= hint_cl;
        end
      end
      ST_A_DN: begin
        if (dn_go) begin
          cur_i_r <= cur_i_r - PW'(1);
        end
      end
      ST_A_UP: begin
        cur_i_r <= up_go ? (cur_i_r + PW'(1)) : up_fin;
      end
      ST_A_P0: begin
        p0_r <= g_data;
      end
      ST_A_P1: begin
        div_d_r   <= 32'(($signed({g_data[31], g_data}) - diff_d));
        div_rem_r <= div_n[48:17];
        div_low_r <= div_n[16:0];
        div_q_r   <= '0;
        div_cnt_r <= DIV_STEPS;
      end
      ST_A_DIV: begin
        div_rem_r <= div_ge ? div_sub[31:0] : div_t[31:0];
        div_low_r <= {div_low_r[15:0], 1'b0};
        div_q_r   <= div_q_nxt;
        div_cnt_r <= div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd1) begin
          cur_f_r <= (div_q_nxt > FRAC_ONE) ? FRAC_ONE : div_q_nxt;
        end
      end
      ST_A_END: begin
        if (axis_r) begin
          j_r    <= cur_i_r;
          twoy_r <= cur_two_r;
          fy_r   <= cur_two_r ? cur_f_r : 17'd0;
        end else begin
          i_r    <= cur_i_r;
          twox_r <= cur_two_r;
          fx_r   <= cur_two_r ? cur_f_r : 17'd0;
          axis_r <= 1'b1;
        end
      end
      ST_Z01, ST_Z11: begin
        acc_r <= mz;
      end
      ST_ZX0, ST_ZX1: begin
        if (twoy_r) begin
          acc_r <= acc_r + mz;
        end
      end
      ST_ZS0: begin
        s_r <= ms;
      end
      ST_ZS1: begin
        s_r <= s_r + ms;
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_r.z_value <= z_sat;
          out_data_r.x_cell  <= 4'(i_r);
          out_data_r.y_cell  <= 4'(j_r);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
